### hw/rtl/ofv_pkg.sv
package ofv_pkg;

    // default component format: signed Q1.14 in 16-bit words
    localparam int COMP_BITS = 16;
    localparam int FRAC_BITS = 14;

    // three lanes for the first perpendicular, three for the cross product
    localparam int LANES   = 6;
    localparam int P_LANES = 3;

endpackage

### hw/rtl/orthonormal_frame_from_vector_unit.sv
// Channel  Direction  Handshake          Payload
// s_       in         s_valid / s_ready  s_vec_x, s_vec_y, s_vec_z
// m_       out        m_valid / m_ready  m_perp_*, m_binorm_*, m_degenerate
//
// One item enters per cycle unless the output stalls; each passes through
// five front stages, one restoring-divide stage per quotient bit, one
// square-root stage per root bit and one output register.
// aresetn (synchronous, active low) clears only the valid bits.
// The whole pipeline advances when the output register is empty or taken, so a
// stall freezes every stage and s_ready follows it.
module orthonormal_frame_from_vector_unit #(
    parameter int COMP_BITS = ofv_pkg::COMP_BITS,
    parameter int FRAC_BITS = ofv_pkg::FRAC_BITS
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [COMP_BITS-1:0] s_vec_x,
    input  logic signed [COMP_BITS-1:0] s_vec_y,
    input  logic signed [COMP_BITS-1:0] s_vec_z,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [COMP_BITS-1:0] m_perp_x,
    output logic signed [COMP_BITS-1:0] m_perp_y,
    output logic signed [COMP_BITS-1:0] m_perp_z,
    output logic signed [COMP_BITS-1:0] m_binorm_x,
    output logic signed [COMP_BITS-1:0] m_binorm_y,
    output logic signed [COMP_BITS-1:0] m_binorm_z,
    output logic                        m_degenerate
);

    localparam int CW  = COMP_BITS;
    localparam int PW  = CW + 1;           // first perpendicular component
    localparam int PR  = 2 * CW + 1;       // x * p product
    localparam int MW  = 2 * CW + 2;       // cross product component
    localparam int SQW = 2 * MW;           // squared magnitude of one component
    localparam int NW  = SQW + 2;          // sum of three squares
    localparam int RW  = NW + 1;           // divider remainder
    localparam int QB  = 2 * FRAC_BITS + 3; // quotient bits
    localparam int RB  = FRAC_BITS + 2;    // root bits
    localparam int TW  = 2 * RB + 1;       // root trial width
    localparam int SW  = ((RB > CW) ? RB : CW) + 1;
    localparam int L   = ofv_pkg::LANES;
    localparam int PL  = ofv_pkg::P_LANES;

    logic adv;
    logic out_valid_reg;

    assign adv     = !out_valid_reg || m_ready;
    assign s_ready = adv;

    // ---------------- stage A: first perpendicular
    logic                 a_valid_reg;
    logic signed [CW-1:0] a_v_reg [0:2];
    logic signed [PW-1:0] a_p_reg [0:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (adv) begin
            a_valid_reg <= s_valid;
        end
        if (adv) begin
            a_v_reg[0] <= s_vec_x;
            a_v_reg[1] <= s_vec_y;
            a_v_reg[2] <= s_vec_z;
            a_p_reg[0] <= PW'(s_vec_y) - PW'(s_vec_z);
            a_p_reg[1] <= PW'(s_vec_z) - PW'(s_vec_x);
            a_p_reg[2] <= PW'(s_vec_x) - PW'(s_vec_y);
        end
    end

    // ---------------- stage B: cross products and squares of p
    logic                  b_valid_reg;
    logic signed [PR-1:0]  b_prod_reg [0:5];
    logic signed [PR-1:0]  b_prod_next [0:5];
    logic [SQW-1:0]        b_psq_reg [0:2];
    logic [PW-1:0]         b_pmag [0:2];
    logic [2:0]            b_pneg_reg;

    always_comb begin
        b_prod_next[0] = a_v_reg[1] * a_p_reg[2];
        b_prod_next[1] = a_v_reg[2] * a_p_reg[1];
        b_prod_next[2] = a_v_reg[2] * a_p_reg[0];
        b_prod_next[3] = a_v_reg[0] * a_p_reg[2];
        b_prod_next[4] = a_v_reg[0] * a_p_reg[1];
        b_prod_next[5] = a_v_reg[1] * a_p_reg[0];
        for (int i = 0; i < 3; i++) begin
            b_pmag[i] = a_p_reg[i][PW-1] ? PW'(-a_p_reg[i]) : PW'(a_p_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (adv) begin
            b_valid_reg <= a_valid_reg;
        end
        if (adv) begin
            for (int i = 0; i < 6; i++) b_prod_reg[i] <= b_prod_next[i];
            for (int i = 0; i < 3; i++) begin
                b_psq_reg[i]  <= SQW'(b_pmag[i]) * SQW'(b_pmag[i]);
                b_pneg_reg[i] <= a_p_reg[i][PW-1];
            end
        end
    end

    // ---------------- stage C: cross product vector, |p|^2
    logic                 c_valid_reg;
    logic signed [MW-1:0] c_b_reg [0:2];
    logic [SQW-1:0]       c_psq_reg [0:2];
    logic [NW-1:0]        c_sp_reg;
    logic [2:0]           c_pneg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (adv) begin
            c_valid_reg <= b_valid_reg;
        end
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                c_b_reg[i]   <= MW'(b_prod_reg[2*i]) - MW'(b_prod_reg[2*i+1]);
                c_psq_reg[i] <= b_psq_reg[i];
            end
            c_sp_reg   <= NW'(b_psq_reg[0]) + NW'(b_psq_reg[1]) + NW'(b_psq_reg[2]);
            c_pneg_reg <= b_pneg_reg;
        end
    end

    // ---------------- stage D: squares of b
    logic           d_valid_reg;
    logic [SQW-1:0] d_sq_reg [0:L-1];
    logic [NW-1:0]  d_sp_reg;
    logic [L-1:0]   d_neg_reg;
    logic [MW-1:0]  d_bmag [0:2];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            d_bmag[i] = c_b_reg[i][MW-1] ? MW'(-c_b_reg[i]) : MW'(c_b_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
        end else if (adv) begin
            d_valid_reg <= c_valid_reg;
        end
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                d_sq_reg[i]       <= c_psq_reg[i];
                d_sq_reg[PL + i]  <= SQW'(d_bmag[i]) * SQW'(d_bmag[i]);
                d_neg_reg[i]      <= c_pneg_reg[i];
                d_neg_reg[PL + i] <= c_b_reg[i][MW-1];
            end
            d_sp_reg <= c_sp_reg;
        end
    end

    // ---------------- stage E / divider: Q = floor(c^2 * 2^(2F+2) / |w|^2)
    logic           dv_valid_reg [0:QB];
    logic [RW-1:0]  dv_rem_reg   [0:QB][0:L-1];
    logic [QB-1:0]  dv_q_reg     [0:QB][0:L-1];
    logic [L-1:0]   dv_lsb_reg   [0:QB];
    logic [L-1:0]   dv_neg_reg   [0:QB];
    logic [NW-1:0]  dv_sp_reg    [0:QB];
    logic [NW-1:0]  dv_sb_reg    [0:QB];
    logic           dv_deg_reg   [0:QB];
    logic [NW-1:0]  e_sb;

    assign e_sb = NW'(d_sq_reg[PL]) + NW'(d_sq_reg[PL+1]) + NW'(d_sq_reg[PL+2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_valid_reg[0] <= 1'b0;
        end else if (adv) begin
            dv_valid_reg[0] <= d_valid_reg;
        end
        if (adv) begin
            for (int i = 0; i < L; i++) begin
                dv_rem_reg[0][i] <= RW'(d_sq_reg[i] >> 1);
                dv_q_reg[0][i]   <= '0;
                dv_lsb_reg[0][i] <= d_sq_reg[i][0];
            end
            dv_neg_reg[0] <= d_neg_reg;
            dv_sp_reg[0]  <= d_sp_reg;
            dv_sb_reg[0]  <= e_sb;
            dv_deg_reg[0] <= (d_sp_reg == '0) || (e_sb == '0);
        end
    end

    for (genvar k = 0; k < QB; k++) begin : g_div
        logic [RW-1:0] shf [0:L-1];
        logic [RW-1:0] den [0:L-1];
        logic [L-1:0]  fit;

        always_comb begin
            for (int i = 0; i < L; i++) begin
                // only the first step pulls in a dividend bit; the rest are zero
                shf[i] = {dv_rem_reg[k][i][RW-2:0], (k == 0) ? dv_lsb_reg[k][i] : 1'b0};
                den[i] = (i < PL) ? RW'(dv_sp_reg[k]) : RW'(dv_sb_reg[k]);
                fit[i] = shf[i] >= den[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_valid_reg[k+1] <= 1'b0;
            end else if (adv) begin
                dv_valid_reg[k+1] <= dv_valid_reg[k];
            end
            if (adv) begin
                for (int i = 0; i < L; i++) begin
                    dv_rem_reg[k+1][i] <= fit[i] ? (shf[i] - den[i]) : shf[i];
                    dv_q_reg[k+1][i]   <= {dv_q_reg[k][i][QB-2:0], fit[i]};
                end
                dv_lsb_reg[k+1] <= dv_lsb_reg[k];
                dv_neg_reg[k+1] <= dv_neg_reg[k];
                dv_sp_reg[k+1]  <= dv_sp_reg[k];
                dv_sb_reg[k+1]  <= dv_sb_reg[k];
                dv_deg_reg[k+1] <= dv_deg_reg[k];
            end
        end
    end

    // ---------------- square root: m = floor(sqrt(Q)), one root bit per stage
    logic           sq_valid [0:RB];
    logic [QB-1:0]  sq_rem   [0:RB][0:L-1];
    logic [RB-1:0]  sq_m     [0:RB][0:L-1];
    logic [L-1:0]   sq_neg   [0:RB];
    logic           sq_deg   [0:RB];

    always_comb begin
        sq_valid[0] = dv_valid_reg[QB];
        for (int i = 0; i < L; i++) begin
            sq_rem[0][i] = dv_q_reg[QB][i];
            sq_m[0][i]   = '0;
        end
        sq_neg[0] = dv_neg_reg[QB];
        sq_deg[0] = dv_deg_reg[QB];
    end

    for (genvar j = 0; j < RB; j++) begin : g_sqrt
        localparam int BIT = RB - 1 - j;
        logic [TW-1:0] trial [0:L-1];
        logic [L-1:0]  take;
        logic           v_reg;
        logic [QB-1:0]  rem_reg [0:L-1];
        logic [RB-1:0]  m_reg   [0:L-1];
        logic [L-1:0]   neg_reg;
        logic           deg_reg;

        // (m + 2^b)^2 - m^2, with m holding only bits above b
        always_comb begin
            for (int i = 0; i < L; i++) begin
                trial[i] = (TW'(sq_m[j][i]) << (BIT + 1)) | (TW'(1) << (2 * BIT));
                take[i]  = TW'(sq_rem[j][i]) >= trial[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg <= 1'b0;
            end else if (adv) begin
                v_reg <= sq_valid[j];
            end
            if (adv) begin
                for (int i = 0; i < L; i++) begin
                    rem_reg[i] <= take[i] ? QB'(TW'(sq_rem[j][i]) - trial[i])
                                          : sq_rem[j][i];
                    m_reg[i]   <= take[i] ? (sq_m[j][i] | (RB'(1) << BIT)) : sq_m[j][i];
                end
                neg_reg <= sq_neg[j];
                deg_reg <= sq_deg[j];
            end
        end

        always_comb begin
            sq_valid[j+1] = v_reg;
            for (int i = 0; i < L; i++) begin
                sq_rem[j+1][i] = rem_reg[i];
                sq_m[j+1][i]   = m_reg[i];
            end
            sq_neg[j+1] = neg_reg;
            sq_deg[j+1] = deg_reg;
        end
    end

    // ---------------- round, saturate, sign, output register
    logic [CW-1:0] out_code_reg [0:L-1];
    logic [CW-1:0] code [0:L-1];
    logic [SW-1:0] qe   [0:L-1];
    logic          out_deg_reg;
    localparam logic [SW-1:0] LIM = SW'(1) << (CW - 1);

    always_comb begin
        for (int i = 0; i < L; i++) begin
            qe[i] = SW'((RB+1)'(sq_m[RB][i]) + (RB+1)'(1) >> 1);
            if (sq_deg[RB]) begin
                code[i] = '0;
            end else if (sq_neg[RB][i]) begin
                code[i] = CW'(SW'(0) - ((qe[i] > LIM) ? LIM : qe[i]));
            end else begin
                code[i] = CW'((qe[i] > LIM - SW'(1)) ? (LIM - SW'(1)) : qe[i]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= sq_valid[RB];
        end
        if (adv) begin
            for (int i = 0; i < L; i++) out_code_reg[i] <= code[i];
            out_deg_reg <= sq_deg[RB];
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_perp_x     = out_code_reg[0];
    assign m_perp_y     = out_code_reg[1];
    assign m_perp_z     = out_code_reg[2];
    assign m_binorm_x   = out_code_reg[3];
    assign m_binorm_y   = out_code_reg[4];
    assign m_binorm_z   = out_code_reg[5];
    assign m_degenerate = out_deg_reg;

endmodule
